>>> sv/tilt_projection_binner_assert.svh
// Assertion macros shared by the tilt projection binner RTL.
`ifndef TILT_PROJECTION_BINNER_ASSERT_SVH
`define TILT_PROJECTION_BINNER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define TPB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tilt_projection_binner: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define TPB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tilt_projection_binner: next-cycle check failed");

`endif

>>> sv/tpb_pkg.sv
// Package of the tilt projection binner: types, widths, register indexes and defaults.
`default_nettype none

package tpb_pkg;

   localparam int MAX_ROWS_DEF = 256;
   localparam int MAX_COLS_DEF = 256;

   localparam int COORD_W  = 21;
   localparam int TRIG_W   = 16;
   localparam int WEIGHT_W = 24;
   localparam int PIXEL_W  = 32;
   localparam int DIM_W    = 9;
   localparam int RDIDX_W  = 8;
   localparam int DIFF_W   = 22;
   localparam int PROD_W   = TRIG_W + DIFF_W;
   localparam int ACC_W    = 40;
   localparam int ROWV_W   = 13;
   localparam int COLV_W   = 17;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 21;

   localparam logic [CSR_IDX_W-1:0] CSR_COS_THETA       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIN_THETA       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TILT_AXIS       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_IN_USE     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCUMULATE_MODE = 3'd5;

   localparam logic signed [TRIG_W-1:0]  COS_RESET  = 16'sd16384;
   localparam logic signed [TRIG_W-1:0]  SIN_RESET  = 16'sd0;
   localparam logic signed [COORD_W-1:0] TILT_RESET = 21'sd0;
   localparam logic [DIM_W-1:0]          ROWS_RESET = 9'd256;
   localparam logic [DIM_W-1:0]          COLS_RESET = 9'd256;
   localparam logic                      ACC_RESET  = 1'b1;

   localparam logic signed [PIXEL_W-1:0] PIXEL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [PIXEL_W-1:0] PIXEL_MIN = 32'sh8000_0000;

   localparam logic CMD_BIN  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_ADDR,
      ST_READ,
      ST_MODIFY
   } tpb_state_type;

endpackage

`default_nettype wire

>>> sv/tpb_req_if.sv
// Input channel of the tilt projection binner: point or read command transfers.
`default_nettype none

interface tpb_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 cmd;
   logic signed [tpb_pkg::COORD_W-1:0]   x_coord;
   logic signed [tpb_pkg::COORD_W-1:0]   y_coord;
   logic signed [tpb_pkg::COORD_W-1:0]   z_coord;
   logic signed [tpb_pkg::WEIGHT_W-1:0]  weight;
   logic [tpb_pkg::RDIDX_W-1:0]          read_row;
   logic [tpb_pkg::RDIDX_W-1:0]          read_col;

   modport source (
      output valid, cmd, x_coord, y_coord, z_coord, weight, read_row, read_col,
      input  ready
   );

   modport sink (
      input  valid, cmd, x_coord, y_coord, z_coord, weight, read_row, read_col,
      output ready
   );
endinterface

`default_nettype wire

>>> sv/tpb_rsp_if.sv
// Result channel of the tilt projection binner: one result transfer per command.
`default_nettype none

interface tpb_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [tpb_pkg::PIXEL_W-1:0]  pixel_value;
   logic                                point_binned;
   logic                                saturated;

   modport source (
      output valid, pixel_value, point_binned, saturated,
      input  ready
   );

   modport sink (
      input  valid, pixel_value, point_binned, saturated,
      output ready
   );
endinterface

`default_nettype wire

>>> sv/tilt_projection_binner.sv
// Tilt projection binner: rotates weighted points onto a projection image held in one memory.
// After reset a clearing pass writes zero to all MAX_ROWS*MAX_COLS pixels, one per cycle;
// no transfer is taken on req_ch during it, while csr writes are taken as ever. Each command
// then passes through the states ST_MUL (the two multiplies), ST_SUM (the column sum), ST_ADDR
// (the bounds test and pixel address), ST_READ (the synchronous memory read) and ST_MODIFY (the
// modify and write-back that also loads the result register). The next command is taken in the
// cycle after the result is loaded, so a command is not taken before the previous one has been
// written back through the pixel memory. A result waiting on rsp_ch does not block the next
// transfer on req_ch; the write-back waits only if the result register is still full.
`default_nettype none
`include "tilt_projection_binner_assert.svh"

module tilt_projection_binner #(
   parameter int MAX_ROWS = tpb_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = tpb_pkg::MAX_COLS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   tpb_req_if.sink                                req_ch,
   tpb_rsp_if.source                              rsp_ch,
   input  wire logic                              csr_write_en,
   input  wire logic [tpb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [tpb_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int COL_W  = $clog2(MAX_COLS);

   // configuration
   logic signed [tpb_pkg::TRIG_W-1:0]   cos_ff;
   logic signed [tpb_pkg::TRIG_W-1:0]   sin_ff;
   logic signed [tpb_pkg::COORD_W-1:0]  tilt_ff;
   logic [tpb_pkg::DIM_W-1:0]           rows_ff;
   logic [tpb_pkg::DIM_W-1:0]           cols_ff;
   logic                                acc_mode_ff;

   // control
   tpb_pkg::tpb_state_type              state_ff, state_in;
   logic [ADDR_W-1:0]                   clr_cnt_ff, clr_cnt_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                req_ready;
   logic                                req_take;
   logic                                mem_we;
   logic                                mem_re;
   logic                                advance;

   // command payload
   logic                                cmd_ff;
   logic signed [tpb_pkg::COORD_W-1:0]  x_ff;
   logic signed [tpb_pkg::COORD_W-1:0]  y_ff;
   logic signed [tpb_pkg::COORD_W-1:0]  z_ff;
   logic signed [tpb_pkg::WEIGHT_W-1:0] w_ff;
   logic [tpb_pkg::RDIDX_W-1:0]         rrow_ff;
   logic [tpb_pkg::RDIDX_W-1:0]         rcol_ff;

   // arithmetic
   logic signed [tpb_pkg::DIFF_W-1:0]   diff_y;
   logic signed [tpb_pkg::DIFF_W-1:0]   diff_z;
   logic signed [tpb_pkg::PROD_W-1:0]   prod_cos_ff, prod_cos_in;
   logic signed [tpb_pkg::PROD_W-1:0]   prod_sin_ff, prod_sin_in;
   logic signed [tpb_pkg::ACC_W-1:0]    acc_ff, acc_in;

   // bounds and address
   logic                                row_sign_ok;
   logic                                col_sign_ok;
   logic [tpb_pkg::ROWV_W-1:0]          row_val;
   logic [tpb_pkg::COLV_W-1:0]          col_val;
   logic [tpb_pkg::ROWV_W-1:0]          sel_row;
   logic [tpb_pkg::COLV_W-1:0]          sel_col;
   logic                                hit_bin;
   logic                                hit_read;
   logic                                hit_ff, hit_in;
   logic [ADDR_W-1:0]                   addr_ff, addr_in;

   // memory
   logic signed [tpb_pkg::PIXEL_W-1:0]  pix_mem [DEPTH];
   logic signed [tpb_pkg::PIXEL_W-1:0]  mem_rdata_ff;
   logic [ADDR_W-1:0]                   mem_waddr;
   logic signed [tpb_pkg::PIXEL_W-1:0]  mem_wdata;

   // modify
   logic signed [tpb_pkg::PIXEL_W:0]    sum_wide;
   logic                                sat_hi;
   logic                                sat_lo;
   logic signed [tpb_pkg::PIXEL_W-1:0]  acc_pix;
   logic signed [tpb_pkg::PIXEL_W-1:0]  new_pix;

   // result register
   logic signed [tpb_pkg::PIXEL_W-1:0]  rsp_pixel_ff, rsp_pixel_in;
   logic                                rsp_binned_ff, rsp_binned_in;
   logic                                rsp_sat_ff, rsp_sat_in;

   // ---------------------------------------------------------------- configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff      <= tpb_pkg::COS_RESET;
         sin_ff      <= tpb_pkg::SIN_RESET;
         tilt_ff     <= tpb_pkg::TILT_RESET;
         rows_ff     <= tpb_pkg::ROWS_RESET;
         cols_ff     <= tpb_pkg::COLS_RESET;
         acc_mode_ff <= tpb_pkg::ACC_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            tpb_pkg::CSR_COS_THETA:       cos_ff      <= csr_wdata[tpb_pkg::TRIG_W-1:0];
            tpb_pkg::CSR_SIN_THETA:       sin_ff      <= csr_wdata[tpb_pkg::TRIG_W-1:0];
            tpb_pkg::CSR_TILT_AXIS:       tilt_ff     <= csr_wdata[tpb_pkg::COORD_W-1:0];
            tpb_pkg::CSR_ROWS_IN_USE:     rows_ff     <= csr_wdata[tpb_pkg::DIM_W-1:0];
            tpb_pkg::CSR_COLS_IN_USE:     cols_ff     <= csr_wdata[tpb_pkg::DIM_W-1:0];
            tpb_pkg::CSR_ACCUMULATE_MODE: acc_mode_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tpb_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      req_ready  = 1'b0;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      advance    = 1'b0;
      case (state_ff)
         tpb_pkg::ST_CLEAR: begin
            mem_we     = 1'b1;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = tpb_pkg::ST_IDLE;
            end
         end
         tpb_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_ch.valid) begin
               state_in = tpb_pkg::ST_MUL;
            end
         end
         tpb_pkg::ST_MUL:  state_in = tpb_pkg::ST_SUM;
         tpb_pkg::ST_SUM:  state_in = tpb_pkg::ST_ADDR;
         tpb_pkg::ST_ADDR: state_in = tpb_pkg::ST_READ;
         tpb_pkg::ST_READ: begin
            mem_re   = 1'b1;
            state_in = tpb_pkg::ST_MODIFY;
         end
         tpb_pkg::ST_MODIFY: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               advance  = 1'b1;
               mem_we   = hit_ff;
               state_in = tpb_pkg::ST_IDLE;
            end
         end
         default: state_in = tpb_pkg::ST_CLEAR;
      endcase
   end

   assign req_ch.ready = req_ready;
   assign req_take     = req_ready && req_ch.valid;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------- command capture
   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff  <= req_ch.cmd;
         x_ff    <= req_ch.x_coord;
         y_ff    <= req_ch.y_coord;
         z_ff    <= req_ch.z_coord;
         w_ff    <= req_ch.weight;
         rrow_ff <= req_ch.read_row;
         rcol_ff <= req_ch.read_col;
      end
   end

   // ---------------------------------------------------------------- rotation
   // z centre is rows_in_use/2 in Q13.8
   assign diff_y = tpb_pkg::DIFF_W'(y_ff) - tpb_pkg::DIFF_W'(tilt_ff);
   assign diff_z = tpb_pkg::DIFF_W'(z_ff) - $signed({6'b0, rows_ff[tpb_pkg::DIM_W-1:1], 8'b0});

   assign prod_cos_in = cos_ff * diff_y;
   assign prod_sin_in = sin_ff * diff_z;

   assign acc_in = tpb_pkg::ACC_W'(prod_cos_ff) + tpb_pkg::ACC_W'(prod_sin_ff)
                 + (tpb_pkg::ACC_W'(tilt_ff) <<< 14);

   always_ff @(posedge clock) begin
      if (state_ff == tpb_pkg::ST_MUL) begin
         prod_cos_ff <= prod_cos_in;
         prod_sin_ff <= prod_sin_in;
      end
      if (state_ff == tpb_pkg::ST_SUM) begin
         acc_ff <= acc_in;
      end
   end

   // ---------------------------------------------------------------- bounds and address
   // truncation toward zero: small negatives land on index zero
   assign row_sign_ok = !x_ff[tpb_pkg::COORD_W-1]
                     || ((&x_ff[tpb_pkg::COORD_W-2:8]) && (|x_ff[7:0]));
   assign col_sign_ok = !acc_ff[tpb_pkg::ACC_W-1]
                     || ((&acc_ff[tpb_pkg::ACC_W-2:22]) && (|acc_ff[21:0]));
   assign row_val = x_ff[tpb_pkg::COORD_W-1] ? '0 : {1'b0, x_ff[tpb_pkg::COORD_W-2:8]};
   assign col_val = acc_ff[tpb_pkg::ACC_W-1] ? '0 : acc_ff[tpb_pkg::ACC_W-2:22];

   assign hit_bin = row_sign_ok && col_sign_ok
                 && (row_val < tpb_pkg::ROWV_W'(MAX_ROWS))
                 && (row_val < tpb_pkg::ROWV_W'(rows_ff))
                 && (col_val < tpb_pkg::COLV_W'(MAX_COLS))
                 && (col_val < tpb_pkg::COLV_W'(cols_ff));
   assign hit_read = (tpb_pkg::ROWV_W'(rrow_ff) < tpb_pkg::ROWV_W'(MAX_ROWS))
                  && (tpb_pkg::COLV_W'(rcol_ff) < tpb_pkg::COLV_W'(MAX_COLS));

   assign sel_row = (cmd_ff == tpb_pkg::CMD_READ) ? tpb_pkg::ROWV_W'(rrow_ff) : row_val;
   assign sel_col = (cmd_ff == tpb_pkg::CMD_READ) ? tpb_pkg::COLV_W'(rcol_ff) : col_val;
   assign hit_in  = (cmd_ff == tpb_pkg::CMD_READ) ? hit_read : hit_bin;
   assign addr_in = ADDR_W'(ROW_W'(sel_row)) * ADDR_W'(MAX_COLS) + ADDR_W'(COL_W'(sel_col));

   always_ff @(posedge clock) begin
      if (state_ff == tpb_pkg::ST_ADDR) begin
         hit_ff  <= hit_in;
         addr_ff <= addr_in;
      end
   end

   // ---------------------------------------------------------------- pixel memory
   assign mem_waddr = (state_ff == tpb_pkg::ST_CLEAR) ? clr_cnt_ff : addr_ff;
   assign mem_wdata = (state_ff == tpb_pkg::ST_CLEAR) ? '0 : new_pix;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pix_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= pix_mem[addr_ff];
      end
   end

   // ---------------------------------------------------------------- modify
   assign sum_wide = (tpb_pkg::PIXEL_W + 1)'(mem_rdata_ff) + (tpb_pkg::PIXEL_W + 1)'(w_ff);
   assign sat_hi   = !sum_wide[tpb_pkg::PIXEL_W] &&  sum_wide[tpb_pkg::PIXEL_W-1];
   assign sat_lo   =  sum_wide[tpb_pkg::PIXEL_W] && !sum_wide[tpb_pkg::PIXEL_W-1];
   assign acc_pix  = sat_hi ? tpb_pkg::PIXEL_MAX :
                     sat_lo ? tpb_pkg::PIXEL_MIN : sum_wide[tpb_pkg::PIXEL_W-1:0];

   always_comb begin
      if (cmd_ff == tpb_pkg::CMD_READ) begin
         new_pix = '0;
      end else if (acc_mode_ff) begin
         new_pix = acc_pix;
      end else begin
         new_pix = tpb_pkg::PIXEL_W'(w_ff);
      end
   end

   assign rsp_pixel_in  = (cmd_ff == tpb_pkg::CMD_READ && hit_ff) ? mem_rdata_ff : '0;
   assign rsp_binned_in = (cmd_ff == tpb_pkg::CMD_BIN) && hit_ff;
   assign rsp_sat_in    = (cmd_ff == tpb_pkg::CMD_BIN) && hit_ff && acc_mode_ff
                       && (sat_hi || sat_lo);

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_pixel_ff  <= rsp_pixel_in;
         rsp_binned_ff <= rsp_binned_in;
         rsp_sat_ff    <= rsp_sat_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.pixel_value  = rsp_pixel_ff;
   assign rsp_ch.point_binned = rsp_binned_ff;
   assign rsp_ch.saturated    = rsp_sat_ff;

   // ---------------------------------------------------------------- assertions
   `TPB_ASSERT_NOW(a_no_take_in_clear, clock, reset, state_ff == tpb_pkg::ST_CLEAR, !req_ch.ready)
   `TPB_ASSERT_NEXT(a_result_loaded, clock, reset, advance, rsp_ch.valid)
   `TPB_ASSERT_NEXT(a_read_flags_clear, clock, reset, advance && cmd_ff == tpb_pkg::CMD_READ,
                    !rsp_ch.point_binned && !rsp_ch.saturated)
   `TPB_ASSERT_NOW(a_sat_needs_bin, clock, reset, rsp_ch.valid && rsp_ch.saturated, rsp_ch.point_binned)

endmodule

`default_nettype wire
